// ===== hw/rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned TOTAL_W     = 61;
  localparam int unsigned LEN_W       = 64;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 104;

  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [5:0] LEN_START     = 6'd56;
  localparam logic [3:0] LEN_BYTES     = 4'd8;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  // Field positions inside out_tdata.
  localparam int unsigned OUT_IDX_LSB   = 32;
  localparam int unsigned OUT_IDENT_LSB = 35;
  localparam int unsigned OUT_IDENT_MSB = 98;

  localparam logic [WORD_W-1:0] HASH_IV [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== hw/rtl/sha256_byte_stream_digest.sv =====
`timescale 1ns / 1ps

// SHA-256 over a byte stream. Each input word carries one message byte in
// in_tdata, in_tuser says whether that byte belongs to the message, and
// in_tlast closes the message (a closing word may carry no byte).
// The digest leaves as eight output words, most significant first, each
// with its index, the 64-bit identity and an error flag in out_tuser that
// marks an empty message (one output word, all fields zero).
// Input bytes are taken one per cycle while idle; the byte that fills a
// 64-byte block starts a compression (64 rounds of the shared round unit,
// then the hash update) during which no input is taken. After in_tlast the
// padding is pushed one byte per cycle, paused by one or two compressions;
// then the eight digest words go out. in_tready is low during all of this.
// The last output word sits in a register while the next message is taken.
// A stall on out_tready holds the output word and halts the digest sequence.
// Reset (rst_n low, synchronous) loads the initial hash values and clears
// the byte count, the block fill and the output valid.
module sha256_byte_stream_digest
  import sha256_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // has_byte
  input  logic                   in_tlast,   // last
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] digest_word, [34:32] word_index, [98:35] identity, [103:99] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,  // empty_error
  output logic                   out_tlast   // last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FINAL,
    S_PAD,
    S_OUT,
    S_EMPTY
  } state_t;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  state_t               state_r, state_nxt;
  logic [WORD_W-1:0]    hash_r [HASH_WORDS];
  logic [WORD_W-1:0]    hash_nxt [HASH_WORDS];
  logic [WORD_W-1:0]    vars_r [HASH_WORDS];
  logic [WORD_W-1:0]    vars_nxt [HASH_WORDS];
  logic [511:0]         win_r, win_nxt;
  logic [5:0]           fill_r, fill_nxt;
  logic [5:0]           round_r, round_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [3:0]           len_cnt_r, len_cnt_nxt;
  logic                 pad_active_r, pad_active_nxt;
  logic                 pad80_done_r, pad80_done_nxt;
  logic [2:0]           out_cnt_r, out_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_err_r, out_err_nxt;
  logic [WORD_W-1:0]    out_word_r, out_word_nxt;
  logic [2:0]           out_idx_r, out_idx_nxt;
  logic [63:0]          out_ident_r, out_ident_nxt;

  // Round datapath.
  logic [WORD_W-1:0] w0, w1, w9, w14, s0, s1, w_new;
  logic [WORD_W-1:0] a, b, c, d, e, f, g, h;
  logic [WORD_W-1:0] big_s0, big_s1, ch, maj, t1, t2;
  logic [63:0]       ident;
  logic              push;
  logic [7:0]        push_byte;
  logic              out_free;
  logic              accept;
  logic [TOTAL_W-1:0] total_inc;

  assign w0  = win_r[511:480];
  assign w1  = win_r[479:448];
  assign w9  = win_r[223:192];
  assign w14 = win_r[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;

  assign a = vars_r[0];
  assign b = vars_r[1];
  assign c = vars_r[2];
  assign d = vars_r[3];
  assign e = vars_r[4];
  assign f = vars_r[5];
  assign g = vars_r[6];
  assign h = vars_r[7];
  assign big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  assign ch     = (e & f) ^ (~e & g);
  assign t1     = h + big_s1 + ch + ROUND_K[round_r] + w0;
  assign big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  assign maj    = (a & b) ^ (a & c) ^ (b & c);
  assign t2     = big_s0 + maj;

  assign ident = ({hash_r[0], hash_r[1]} == 64'd0) ? 64'd1 : {hash_r[0], hash_r[1]};

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign total_inc = total_r + {{(TOTAL_W-1){1'b0}}, in_tuser};

  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    vars_nxt       = vars_r;
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    round_nxt      = round_r;
    total_nxt      = total_r;
    len_nxt        = len_r;
    len_cnt_nxt    = len_cnt_r;
    pad_active_nxt = pad_active_r;
    pad80_done_nxt = pad80_done_r;
    out_cnt_nxt    = out_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;
    out_word_nxt   = out_word_r;
    out_idx_nxt    = out_idx_r;
    out_ident_nxt  = out_ident_r;
    push           = 1'b0;
    push_byte      = 8'd0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          total_nxt = total_inc;
          if (in_tuser) begin
            push      = 1'b1;
            push_byte = in_tdata;
          end
          if (in_tlast) begin
            len_nxt = {total_inc, 3'b000};
            if (total_inc == '0) begin
              state_nxt = S_EMPTY;
            end else begin
              pad_active_nxt = 1'b1;
              pad80_done_nxt = 1'b0;
              len_cnt_nxt    = '0;
              state_nxt      = S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        push = 1'b1;
        if (!pad80_done_r) begin
          push_byte      = PAD_BYTE;
          pad80_done_nxt = 1'b1;
        end else if (len_cnt_r == '0 && fill_r != LEN_START) begin
          push_byte = 8'd0;
        end else begin
          push_byte   = len_r[63:56];
          len_nxt     = {len_r[55:0], 8'd0};
          len_cnt_nxt = len_cnt_r + 4'd1;
        end
      end
      S_ROUND: begin
        win_nxt     = {win_r[479:0], w_new};
        vars_nxt[7] = g;
        vars_nxt[6] = f;
        vars_nxt[5] = e;
        vars_nxt[4] = d + t1;
        vars_nxt[3] = c;
        vars_nxt[2] = b;
        vars_nxt[1] = a;
        vars_nxt[0] = t1 + t2;
        round_nxt   = round_r + 6'd1;
        if (round_r == 6'(ROUNDS - 1)) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          hash_nxt[i] = hash_r[i] + vars_r[i];
        end
        if (!pad_active_r) begin
          state_nxt = S_IDLE;
        end else if (len_cnt_r == LEN_BYTES) begin
          out_cnt_nxt = '0;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hash_r[out_cnt_r];
          out_idx_nxt   = out_cnt_r;
          out_last_nxt  = (out_cnt_r == LAST_WORD_IDX);
          out_ident_nxt = ident;
          out_err_nxt   = 1'b0;
          out_cnt_nxt   = out_cnt_r + 3'd1;
          if (out_cnt_r == LAST_WORD_IDX) begin
            state_nxt = S_EMPTY;
          end
        end
      end
      S_EMPTY: begin
        // Reached twice: after the last digest word (already loaded) and for
        // an empty message, which still owes its error word.
        if (pad_active_r) begin
          pad_active_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          out_idx_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_ident_nxt = '0;
          out_err_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
        if (pad_active_r || out_free) begin
          hash_nxt    = HASH_IV;
          fill_nxt    = '0;
          total_nxt   = '0;
          len_cnt_nxt = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A byte push shifts the block buffer; the 64th byte starts a compression.
    if (push) begin
      win_nxt  = {win_r[503:0], push_byte};
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        vars_nxt  = hash_r;
        round_nxt = '0;
        if (state_nxt != S_EMPTY) begin
          state_nxt = S_ROUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hash_r       <= HASH_IV;
      fill_r       <= '0;
      total_r      <= '0;
      len_cnt_r    <= '0;
      pad_active_r <= 1'b0;
      pad80_done_r <= 1'b0;
      out_cnt_r    <= '0;
      round_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hash_r       <= hash_nxt;
      fill_r       <= fill_nxt;
      total_r      <= total_nxt;
      len_cnt_r    <= len_cnt_nxt;
      pad_active_r <= pad_active_nxt;
      pad80_done_r <= pad80_done_nxt;
      out_cnt_r    <= out_cnt_nxt;
      round_r      <= round_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    vars_r      <= vars_nxt;
    win_r       <= win_nxt;
    len_r       <= len_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
    out_word_r  <= out_word_nxt;
    out_idx_r   <= out_idx_nxt;
    out_ident_r <= out_ident_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;
  assign out_tdata  = {5'd0, out_ident_r, out_idx_r, out_word_r};

endmodule

// ===== hw/rtl/sha256_checker.sv =====
`timescale 1ns / 1ps

module sha256_checker
  import sha256_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // An offered input word waits unchanged until the block takes it.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) &&
      $stable(in_tuser) && $stable(in_tlast))
    else $error("input word changed while waiting");

  // A stalled output word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // The empty-message word is a lone closing word with all fields zero.
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == '0)
    else $error("empty-message word malformed");

  // A digest word always carries a nonzero identity.
  a_ident_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[OUT_IDENT_MSB:OUT_IDENT_LSB] != '0)
    else $error("zero identity on a digest word");

  // The closing digest word is the least significant one.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tlast == (out_tdata[OUT_IDENT_LSB-1:OUT_IDX_LSB] == LAST_WORD_IDX)))
    else $error("last marker does not match the word index");

endmodule

bind sha256_byte_stream_digest sha256_checker u_sha256_checker (.*);
